// ----- hw/rtl/tpcf_pkg.sv -----
// ----------------------------------------------------------------------------
// tpcf_pkg: shared types and constants of the three point circle fit
// Holds datapath widths, result codes, the multiply-accumulate micro program
// and the control structs passed between the sequencer and its units.
// ----------------------------------------------------------------------------
`default_nettype none

package tpcf_pkg;

  // coordinate and datapath widths
  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIFF_W  = COORD_W + 1;     // point differences
  localparam int unsigned OPND_W  = DIFF_W + 1;      // multiplier operand
  localparam int unsigned PROD_W  = 2 * OPND_W;      // multiplier product
  localparam int unsigned LIMB_SH = DIFF_W;          // weight of an upper limb
  localparam int unsigned ACC_W   = 104;             // accumulator
  localparam int unsigned DET_W   = 2 * DIFF_W + 1;  // signed determinant
  localparam int unsigned MAG_W   = 2 * DIFF_W;      // |det|, squared lengths
  localparam int unsigned NUM_W   = 101;             // dividend / remainder
  localparam int unsigned DEN_W   = MAG_W + 1;       // divisor 2*|det|
  localparam int unsigned QUO_W   = DIFF_W;          // quotient bits kept
  localparam int unsigned ROOT_W  = 34;              // root / shift register
  localparam int unsigned SREM_W  = 36;              // root remainder
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned STEP_W  = 4;

  localparam logic [THR_W-1:0]  THR_RESET      = 16'd4;
  localparam logic [STEP_W-1:0] STEP_GEO_FIRST = 4'd0;
  localparam logic [STEP_W-1:0] STEP_GEO_LAST  = 4'd13;
  localparam logic [STEP_W-1:0] STEP_RAD_FIRST = 4'd14;
  localparam logic [STEP_W-1:0] STEP_RAD_LAST  = 4'd15;

  localparam logic CMD_CANCEL = 1'b1;

  typedef enum logic [2:0] {
    STAT_START     = 3'd0,
    STAT_MID       = 3'd1,
    STAT_ARC       = 3'd2,
    STAT_COLLINEAR = 3'd3,
    STAT_CANCEL    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    STG_START = 2'd0,
    STG_MID   = 2'd1,
    STG_END   = 2'd2
  } stage_e;

  typedef enum logic [3:0] {
    OP_AX    = 4'd0,
    OP_AY    = 4'd1,
    OP_BX    = 4'd2,
    OP_BY    = 4'd3,
    OP_QX    = 4'd4,
    OP_QY    = 4'd5,
    OP_AA_LO = 4'd6,
    OP_AA_HI = 4'd7,
    OP_BB_LO = 4'd8,
    OP_BB_HI = 4'd9
  } opnd_e;

  typedef enum logic [2:0] {
    DST_NONE  = 3'd0,
    DST_DET   = 3'd1,
    DST_AA    = 3'd2,
    DST_BB    = 3'd3,
    DST_NX    = 3'd4,
    DST_NY    = 3'd5,
    DST_SUMSQ = 3'd6
  } dest_e;

  typedef enum logic {
    IT_DIV  = 1'b0,
    IT_SQRT = 1'b1
  } iter_mode_e;

  typedef struct packed {
    opnd_e a;
    opnd_e b;
    logic  sub;
    logic  shift;
    logic  clr;
    dest_e dest;
  } mac_op_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic clr;
    logic sub;
    logic shift;
  } mac_ctl_t;

  // micro program: determinant, squared lengths, numerators, then radius sum
  function automatic mac_op_t mac_op(input logic [STEP_W-1:0] step);
    mac_op_t op;
    op = '{OP_AX, OP_AX, 1'b0, 1'b0, 1'b0, DST_NONE};
    case (step)
      4'd0:  op = '{OP_AX, OP_BY,    1'b0, 1'b0, 1'b1, DST_NONE};
      4'd1:  op = '{OP_AY, OP_BX,    1'b1, 1'b0, 1'b0, DST_DET};
      4'd2:  op = '{OP_AX, OP_AX,    1'b0, 1'b0, 1'b1, DST_NONE};
      4'd3:  op = '{OP_AY, OP_AY,    1'b0, 1'b0, 1'b0, DST_AA};
      4'd4:  op = '{OP_BX, OP_BX,    1'b0, 1'b0, 1'b1, DST_NONE};
      4'd5:  op = '{OP_BY, OP_BY,    1'b0, 1'b0, 1'b0, DST_BB};
      4'd6:  op = '{OP_BY, OP_AA_LO, 1'b0, 1'b0, 1'b1, DST_NONE};
      4'd7:  op = '{OP_BY, OP_AA_HI, 1'b0, 1'b1, 1'b0, DST_NONE};
      4'd8:  op = '{OP_AY, OP_BB_LO, 1'b1, 1'b0, 1'b0, DST_NONE};
      4'd9:  op = '{OP_AY, OP_BB_HI, 1'b1, 1'b1, 1'b0, DST_NX};
      4'd10: op = '{OP_AX, OP_BB_LO, 1'b0, 1'b0, 1'b1, DST_NONE};
      4'd11: op = '{OP_AX, OP_BB_HI, 1'b0, 1'b1, 1'b0, DST_NONE};
      4'd12: op = '{OP_BX, OP_AA_LO, 1'b1, 1'b0, 1'b0, DST_NONE};
      4'd13: op = '{OP_BX, OP_AA_HI, 1'b1, 1'b1, 1'b0, DST_NY};
      4'd14: op = '{OP_QX, OP_QX,    1'b0, 1'b0, 1'b1, DST_NONE};
      4'd15: op = '{OP_QY, OP_QY,    1'b0, 1'b0, 1'b0, DST_SUMSQ};
      default: op = '{OP_AX, OP_AX, 1'b0, 1'b0, 1'b0, DST_NONE};
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tpcf_if.sv -----
// ----------------------------------------------------------------------------
// tpcf_if: point and result channels of the three point circle fit
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpcf_pt_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] point_x;
  logic [31:0] point_y;

  modport source (output valid, output command, output point_x, output point_y,
                  input ready);
  modport sink (input valid, input command, input point_x, input point_y,
                output ready);
endinterface

interface tpcf_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] center_x;
  logic [31:0] center_y;
  logic [31:0] radius;
  logic        saturated;

  modport source (output valid, output status, output center_x, output center_y,
                  output radius, output saturated, input ready);
  modport sink (input valid, input status, input center_x, input center_y,
                input radius, input saturated, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tpcf_mac.sv -----
// ----------------------------------------------------------------------------
// tpcf_mac: shared multiply-accumulate unit
// One signed multiply per step, registered, then added to or subtracted from
// the accumulator, optionally weighted by one upper limb.
// ----------------------------------------------------------------------------
`default_nettype none

module tpcf_mac (
  input  wire                                 clk_i,
  input  tpcf_pkg::mac_ctl_t                  ctl_i,
  input  wire signed [tpcf_pkg::OPND_W-1:0]   op_a_i,
  input  wire signed [tpcf_pkg::OPND_W-1:0]   op_b_i,
  output logic signed [tpcf_pkg::ACC_W-1:0]   acc_d_o
);

  logic signed [tpcf_pkg::PROD_W-1:0] prod_q;
  logic signed [tpcf_pkg::ACC_W-1:0]  acc_q;
  logic signed [tpcf_pkg::ACC_W-1:0]  base;
  logic signed [tpcf_pkg::ACC_W-1:0]  term;

  always_comb begin
    base = ctl_i.clr ? '0 : acc_q;
    term = {{(tpcf_pkg::ACC_W - tpcf_pkg::PROD_W){prod_q[tpcf_pkg::PROD_W-1]}}, prod_q};
    if (ctl_i.shift) begin
      term = term <<< tpcf_pkg::LIMB_SH;
    end
    acc_d_o = ctl_i.sub ? (base - term) : (base + term);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= op_a_i * op_b_i;
    end
    if (ctl_i.acc_en) begin
      acc_q <= acc_d_o;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tpcf_iter.sv -----
// ----------------------------------------------------------------------------
// tpcf_iter: shared shift-subtract unit for division and square root
// Restoring division producing one quotient bit per cycle, or a digit-by-digit
// square root producing one root bit per cycle; both share one subtractor.
// ----------------------------------------------------------------------------
`default_nettype none

module tpcf_iter (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  input  tpcf_pkg::iter_mode_e             mode_i,
  input  wire  [tpcf_pkg::NUM_W-1:0]       num_i,
  input  wire  [tpcf_pkg::DEN_W-1:0]       den_i,
  input  wire  [tpcf_pkg::MAG_W-1:0]       rad_i,
  output logic                             done_o,
  output logic [tpcf_pkg::QUO_W-1:0]       quo_o,
  output logic [tpcf_pkg::ROOT_W-1:0]      root_o,
  output logic [tpcf_pkg::SREM_W-1:0]      srem_o
);

  localparam logic [tpcf_pkg::CNT_W-1:0] LastCnt = tpcf_pkg::CNT_W'(tpcf_pkg::QUO_W - 1);

  logic                             busy_q;
  logic [tpcf_pkg::CNT_W-1:0]       cnt_q;
  tpcf_pkg::iter_mode_e             mode_q;
  logic [tpcf_pkg::NUM_W-1:0]       rem_q;
  logic [tpcf_pkg::NUM_W-1:0]       dsh_q;
  logic [tpcf_pkg::ROOT_W-1:0]      res_q;
  logic [tpcf_pkg::MAG_W-1:0]       src_q;

  logic [tpcf_pkg::SREM_W-1:0]      r2;
  logic [tpcf_pkg::SREM_W-1:0]      trial;
  logic [tpcf_pkg::NUM_W-1:0]       opa;
  logic [tpcf_pkg::NUM_W-1:0]       opb;
  logic [tpcf_pkg::NUM_W:0]         diff;
  logic                             ge;

  always_comb begin
    r2    = {rem_q[tpcf_pkg::SREM_W-3:0], src_q[tpcf_pkg::MAG_W-1 -: 2]};
    trial = {res_q, 2'b01};
    if (mode_q == tpcf_pkg::IT_SQRT) begin
      opa = tpcf_pkg::NUM_W'(r2);
      opb = tpcf_pkg::NUM_W'(trial);
    end else begin
      opa = rem_q;
      opb = dsh_q;
    end
    diff   = {1'b0, opa} - {1'b0, opb};
    ge     = ~diff[tpcf_pkg::NUM_W];
    done_o = busy_q && (cnt_q == '0);
    quo_o  = res_q[tpcf_pkg::QUO_W-1:0];
    root_o = res_q;
    srem_o = rem_q[tpcf_pkg::SREM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= LastCnt;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mode_q <= mode_i;
      rem_q  <= (mode_i == tpcf_pkg::IT_DIV) ? num_i : '0;
      dsh_q  <= tpcf_pkg::NUM_W'({den_i, {(tpcf_pkg::QUO_W - 1){1'b0}}});
      res_q  <= '0;
      src_q  <= rad_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[tpcf_pkg::NUM_W-1:0] : opa;
      dsh_q <= dsh_q >> 1;
      res_q <= {res_q[tpcf_pkg::ROOT_W-2:0], ge};
      src_q <= src_q << 2;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/three_point_circle_fit.sv -----
// ----------------------------------------------------------------------------
// three_point_circle_fit: circle through three picked points, Q16.16
// Keeps a start and a middle point; the third point closes the fit and the
// block reports the center and radius of the circle through all three.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  pt_i      in   valid / ready    command, point_x, point_y
//  res_o     out  valid / ready    status, center_x, center_y, radius, saturated
//  cfg       in   cfg_we_i         cfg_wdata_i -> collinear threshold
//
// Start, middle and cancel transactions pass through the write-back state into
// the output register, which loads when it is free or being read. An end point
// runs 14 multiply-accumulate steps; unless the points are collinear, it then
// makes two divisions in the shared bit-serial divide / square root unit and,
// when both quotients are in range, a two-step radius sum and a square root.
// Ready is high only while the sequencer is idle; a result waiting in the
// output register does not block the next transaction until its write-back.
// Reset clears the pick stage, sequencer and threshold (to 4); stored points
// are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module three_point_circle_fit (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  tpcf_pt_if.sink                       pt_i,
  tpcf_res_if.source                    res_o,
  input  wire                           cfg_we_i,
  input  wire  [tpcf_pkg::THR_W-1:0]    cfg_wdata_i
);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_MAC  = 13'b0000000000010,
    S_ABS  = 13'b0000000000100,
    S_COL  = 13'b0000000001000,
    S_PREP = 13'b0000000010000,
    S_DGO  = 13'b0000000100000,
    S_DIV  = 13'b0000001000000,
    S_DSV  = 13'b0000010000000,
    S_CEN  = 13'b0000100000000,
    S_SQS  = 13'b0001000000000,
    S_SQW  = 13'b0010000000000,
    S_RND  = 13'b0100000000000,
    S_WB   = 13'b1000000000000
  } state_e;

  typedef struct packed {
    logic [tpcf_pkg::COORD_W-1:0] val;
    logic                         sat;
  } cen_t;

  localparam int unsigned CW = tpcf_pkg::COORD_W;
  localparam logic [CW-1:0] CoordMin = {1'b1, {(CW - 1){1'b0}}};
  localparam logic [CW-1:0] CoordMax = {1'b0, {(CW - 1){1'b1}}};
  localparam logic [CW-1:0] RadMax   = {CW{1'b1}};

  // center = base +/- quotient, clamped to the signed coordinate range
  function automatic cen_t center_of(input logic [CW-1:0] base,
                                     input logic [tpcf_pkg::QUO_W-1:0] q,
                                     input logic neg, input logic ovf);
    cen_t r;
    logic [CW+2:0] be;
    logic [CW+2:0] qe;
    logic [CW+2:0] sum;
    be  = {{3{base[CW-1]}}, base};
    qe  = {2'b00, q};
    sum = neg ? (be - qe) : (be + qe);
    r.sat = 1'b0;
    r.val = sum[CW-1:0];
    if (ovf) begin
      r.sat = 1'b1;
      r.val = neg ? CoordMin : CoordMax;
    end else if (sum[CW+2:CW-1] != '0 && sum[CW+2:CW-1] != '1) begin
      r.sat = 1'b1;
      r.val = sum[CW+2] ? CoordMin : CoordMax;
    end
    return r;
  endfunction

  // control state
  state_e                        state_q;
  tpcf_pkg::stage_e              stage_q;
  logic [tpcf_pkg::THR_W-1:0]    thr_q;
  logic [tpcf_pkg::STEP_W-1:0]   step_q;
  logic                          phase_q;
  logic                          sel_y_q;
  logic                          out_valid_q;

  // payload
  logic [CW-1:0]                       start_x_q, start_y_q, mid_x_q, mid_y_q;
  logic signed [tpcf_pkg::DIFF_W-1:0]  ax_q, ay_q, bx_q, by_q;
  logic signed [tpcf_pkg::DET_W-1:0]   det_q;
  logic [tpcf_pkg::MAG_W-1:0]          aa_q, bb_q, s_q, det_abs_q;
  logic                                det_neg_q;
  logic signed [tpcf_pkg::NUM_W-1:0]   nx_q, ny_q;
  logic [tpcf_pkg::NUM_W-1:0]          n_q;
  logic                                neg_q, ovf_q;
  logic [tpcf_pkg::QUO_W-1:0]          qx_q, qy_q;
  logic                                negx_q, negy_q, ovfx_q, ovfy_q;
  tpcf_pkg::status_e                   res_status_q, out_status_q;
  logic [CW-1:0]                       res_cx_q, res_cy_q, res_rad_q;
  logic [CW-1:0]                       out_cx_q, out_cy_q, out_rad_q;
  logic                                res_sat_q, out_sat_q;

  // unit wiring
  tpcf_pkg::mac_op_t                   op;
  tpcf_pkg::mac_ctl_t                  mac_ctl;
  logic signed [tpcf_pkg::OPND_W-1:0]  op_a, op_b;
  logic signed [tpcf_pkg::ACC_W-1:0]   acc_d;
  logic                                it_start, it_done;
  tpcf_pkg::iter_mode_e                it_mode;
  logic [tpcf_pkg::DEN_W-1:0]          dd;
  logic [tpcf_pkg::QUO_W-1:0]          it_quo;
  logic [tpcf_pkg::ROOT_W-1:0]         it_root;
  logic [tpcf_pkg::SREM_W-1:0]         it_srem;

  logic                                pt_fire;
  logic                                wb_go;
  logic signed [tpcf_pkg::NUM_W-1:0]   num_sel;
  logic [tpcf_pkg::NUM_W:0]            num_sum;
  logic [tpcf_pkg::ROOT_W-1:0]         rad_round;
  cen_t                                cx, cy;

  function automatic logic signed [tpcf_pkg::OPND_W-1:0] opnd(input tpcf_pkg::opnd_e sel,
      input logic signed [tpcf_pkg::DIFF_W-1:0] ax, input logic signed [tpcf_pkg::DIFF_W-1:0] ay,
      input logic signed [tpcf_pkg::DIFF_W-1:0] bx, input logic signed [tpcf_pkg::DIFF_W-1:0] by,
      input logic [tpcf_pkg::QUO_W-1:0] qx, input logic [tpcf_pkg::QUO_W-1:0] qy,
      input logic [tpcf_pkg::MAG_W-1:0] aa, input logic [tpcf_pkg::MAG_W-1:0] bb);
    logic signed [tpcf_pkg::OPND_W-1:0] r;
    case (sel)
      tpcf_pkg::OP_AX:    r = {ax[tpcf_pkg::DIFF_W-1], ax};
      tpcf_pkg::OP_AY:    r = {ay[tpcf_pkg::DIFF_W-1], ay};
      tpcf_pkg::OP_BX:    r = {bx[tpcf_pkg::DIFF_W-1], bx};
      tpcf_pkg::OP_BY:    r = {by[tpcf_pkg::DIFF_W-1], by};
      tpcf_pkg::OP_QX:    r = {1'b0, qx};
      tpcf_pkg::OP_QY:    r = {1'b0, qy};
      tpcf_pkg::OP_AA_LO: r = {1'b0, aa[tpcf_pkg::LIMB_SH-1:0]};
      tpcf_pkg::OP_AA_HI: r = {1'b0, aa[tpcf_pkg::MAG_W-1:tpcf_pkg::LIMB_SH]};
      tpcf_pkg::OP_BB_LO: r = {1'b0, bb[tpcf_pkg::LIMB_SH-1:0]};
      tpcf_pkg::OP_BB_HI: r = {1'b0, bb[tpcf_pkg::MAG_W-1:tpcf_pkg::LIMB_SH]};
      default:            r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    op   = tpcf_pkg::mac_op(step_q);
    op_a = opnd(op.a, ax_q, ay_q, bx_q, by_q, qx_q, qy_q, aa_q, bb_q);
    op_b = opnd(op.b, ax_q, ay_q, bx_q, by_q, qx_q, qy_q, aa_q, bb_q);
    mac_ctl.mul_en = (state_q == S_MAC) && !phase_q;
    mac_ctl.acc_en = (state_q == S_MAC) && phase_q;
    mac_ctl.clr    = op.clr;
    mac_ctl.sub    = op.sub;
    mac_ctl.shift  = op.shift;

    dd       = {det_abs_q, 1'b0};
    it_start = (state_q == S_DGO) || (state_q == S_SQS);
    it_mode  = (state_q == S_SQS) ? tpcf_pkg::IT_SQRT : tpcf_pkg::IT_DIV;

    pt_fire  = pt_i.valid && pt_i.ready;
    wb_go    = (state_q == S_WB) && (!out_valid_q || res_o.ready);

    // |num| + |det| folded into one add or subtract
    num_sel = sel_y_q ? ny_q : nx_q;
    if (num_sel[tpcf_pkg::NUM_W-1]) begin
      num_sum = (tpcf_pkg::NUM_W + 1)'(det_abs_q) - {num_sel[tpcf_pkg::NUM_W-1], num_sel};
    end else begin
      num_sum = (tpcf_pkg::NUM_W + 1)'(det_abs_q) + {num_sel[tpcf_pkg::NUM_W-1], num_sel};
    end

    // round the root to nearest: bump when the remainder exceeds the root
    rad_round = it_root + tpcf_pkg::ROOT_W'(it_srem > tpcf_pkg::SREM_W'(it_root));

    cx = center_of(start_x_q, qx_q, negx_q, ovfx_q);
    cy = center_of(start_y_q, qy_q, negy_q, ovfy_q);
  end

  assign pt_i.ready      = (state_q == S_IDLE);
  assign res_o.valid     = out_valid_q;
  assign res_o.status    = out_status_q;
  assign res_o.center_x  = out_cx_q;
  assign res_o.center_y  = out_cy_q;
  assign res_o.radius    = out_rad_q;
  assign res_o.saturated = out_sat_q;

  tpcf_mac u_mac (
    .clk_i   (clk_i),
    .ctl_i   (mac_ctl),
    .op_a_i  (op_a),
    .op_b_i  (op_b),
    .acc_d_o (acc_d)
  );

  tpcf_iter u_iter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (it_start),
    .mode_i  (it_mode),
    .num_i   (n_q),
    .den_i   (dd),
    .rad_i   (s_q),
    .done_o  (it_done),
    .quo_o   (it_quo),
    .root_o  (it_root),
    .srem_o  (it_srem)
  );

  // sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stage_q     <= tpcf_pkg::STG_START;
      thr_q       <= tpcf_pkg::THR_RESET;
      step_q      <= tpcf_pkg::STEP_GEO_FIRST;
      phase_q     <= 1'b0;
      sel_y_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      // load a new result, or drop the one the receiver took
      if (wb_go) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pt_fire) begin
            if (pt_i.command == tpcf_pkg::CMD_CANCEL) begin
              stage_q <= tpcf_pkg::STG_START;
              state_q <= S_WB;
            end else begin
              case (stage_q)
                tpcf_pkg::STG_MID: begin
                  stage_q <= tpcf_pkg::STG_END;
                  state_q <= S_WB;
                end
                tpcf_pkg::STG_END: begin
                  step_q  <= tpcf_pkg::STEP_GEO_FIRST;
                  phase_q <= 1'b0;
                  state_q <= S_MAC;
                end
                default: begin
                  stage_q <= tpcf_pkg::STG_MID;
                  state_q <= S_WB;
                end
              endcase
            end
          end
        end
        S_MAC: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            step_q <= step_q + 1'b1;
            if (step_q == tpcf_pkg::STEP_GEO_LAST) begin
              state_q <= S_ABS;
            end else if (step_q == tpcf_pkg::STEP_RAD_LAST) begin
              state_q <= S_SQS;
            end
          end
        end
        S_ABS: state_q <= S_COL;
        S_COL: begin
          if (det_abs_q == '0 || det_abs_q < tpcf_pkg::MAG_W'(thr_q)) begin
            state_q <= S_WB;
          end else begin
            stage_q <= tpcf_pkg::STG_START;
            sel_y_q <= 1'b0;
            state_q <= S_PREP;
          end
        end
        S_PREP: state_q <= S_DGO;
        S_DGO:  state_q <= S_DIV;
        S_DIV: begin
          if (it_done) begin
            state_q <= S_DSV;
          end
        end
        S_DSV: begin
          sel_y_q <= 1'b1;
          state_q <= sel_y_q ? S_CEN : S_PREP;
        end
        S_CEN: begin
          if (ovfx_q || ovfy_q || qx_q[tpcf_pkg::QUO_W-1] || qy_q[tpcf_pkg::QUO_W-1]) begin
            state_q <= S_WB;
          end else begin
            step_q  <= tpcf_pkg::STEP_RAD_FIRST;
            phase_q <= 1'b0;
            state_q <= S_MAC;
          end
        end
        S_SQS: state_q <= S_SQW;
        S_SQW: begin
          if (it_done) begin
            state_q <= S_RND;
          end
        end
        S_RND: state_q <= S_WB;
        S_WB: begin
          if (wb_go) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (pt_fire) begin
      res_cx_q  <= '0;
      res_cy_q  <= '0;
      res_rad_q <= '0;
      res_sat_q <= 1'b0;
      if (pt_i.command == tpcf_pkg::CMD_CANCEL) begin
        res_status_q <= tpcf_pkg::STAT_CANCEL;
      end else begin
        case (stage_q)
          tpcf_pkg::STG_MID: begin
            mid_x_q      <= pt_i.point_x;
            mid_y_q      <= pt_i.point_y;
            res_status_q <= tpcf_pkg::STAT_MID;
          end
          tpcf_pkg::STG_END: begin
            ax_q <= {mid_x_q[CW-1], mid_x_q} - {start_x_q[CW-1], start_x_q};
            ay_q <= {mid_y_q[CW-1], mid_y_q} - {start_y_q[CW-1], start_y_q};
            bx_q <= {pt_i.point_x[CW-1], pt_i.point_x} - {start_x_q[CW-1], start_x_q};
            by_q <= {pt_i.point_y[CW-1], pt_i.point_y} - {start_y_q[CW-1], start_y_q};
            res_status_q <= tpcf_pkg::STAT_COLLINEAR;
          end
          default: begin
            start_x_q    <= pt_i.point_x;
            start_y_q    <= pt_i.point_y;
            res_status_q <= tpcf_pkg::STAT_START;
          end
        endcase
      end
    end

    // capture accumulator results at the end of each group
    if (mac_ctl.acc_en) begin
      case (op.dest)
        tpcf_pkg::DST_DET:   det_q <= acc_d[tpcf_pkg::DET_W-1:0];
        tpcf_pkg::DST_AA:    aa_q  <= acc_d[tpcf_pkg::MAG_W-1:0];
        tpcf_pkg::DST_BB:    bb_q  <= acc_d[tpcf_pkg::MAG_W-1:0];
        tpcf_pkg::DST_NX:    nx_q  <= acc_d[tpcf_pkg::NUM_W-1:0];
        tpcf_pkg::DST_NY:    ny_q  <= acc_d[tpcf_pkg::NUM_W-1:0];
        tpcf_pkg::DST_SUMSQ: s_q   <= acc_d[tpcf_pkg::MAG_W-1:0];
        default: ;
      endcase
    end

    if (state_q == S_ABS) begin
      det_neg_q <= det_q[tpcf_pkg::DET_W-1];
      det_abs_q <= det_q[tpcf_pkg::DET_W-1] ? tpcf_pkg::MAG_W'(-det_q)
                                            : det_q[tpcf_pkg::MAG_W-1:0];
    end

    if (state_q == S_PREP) begin
      n_q   <= num_sum[tpcf_pkg::NUM_W-1:0];
      neg_q <= num_sel[tpcf_pkg::NUM_W-1] ^ det_neg_q;
    end

    // quotient too large for the kept bits: flag overflow
    if (state_q == S_DGO) begin
      ovf_q <= (n_q >= tpcf_pkg::NUM_W'({dd, {tpcf_pkg::QUO_W{1'b0}}}));
    end

    if (state_q == S_DSV) begin
      if (sel_y_q) begin
        qy_q   <= it_quo;
        ovfy_q <= ovf_q;
        negy_q <= neg_q && (ovf_q || it_quo != '0);
      end else begin
        qx_q   <= it_quo;
        ovfx_q <= ovf_q;
        negx_q <= neg_q && (ovf_q || it_quo != '0);
      end
    end

    if (state_q == S_CEN) begin
      res_status_q <= tpcf_pkg::STAT_ARC;
      res_cx_q     <= cx.val;
      res_cy_q     <= cy.val;
      if (ovfx_q || ovfy_q || qx_q[tpcf_pkg::QUO_W-1] || qy_q[tpcf_pkg::QUO_W-1]) begin
        res_rad_q <= RadMax;
        res_sat_q <= 1'b1;
      end else begin
        res_sat_q <= cx.sat || cy.sat;
      end
    end

    if (state_q == S_RND) begin
      if (rad_round[tpcf_pkg::ROOT_W-1:CW] != '0) begin
        res_rad_q <= RadMax;
        res_sat_q <= 1'b1;
      end else begin
        res_rad_q <= rad_round[CW-1:0];
      end
    end

    if (wb_go) begin
      out_status_q <= res_status_q;
      out_cx_q     <= res_cx_q;
      out_cy_q     <= res_cy_q;
      out_rad_q    <= res_rad_q;
      out_sat_q    <= res_sat_q;
    end
  end

  // the shared unit only finishes while the sequencer waits for it
  a_iter_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    it_done |-> (state_q == S_DIV || state_q == S_SQW))
    else $error("iterative unit finished outside a wait state");

  // a pending result is never overwritten
  a_wb_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB && out_valid_q && !res_o.ready) |=> (state_q == S_WB && out_valid_q))
    else $error("write-back did not hold for a full output register");

  // cancel always returns to the start stage and goes straight to write-back
  a_cancel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_fire && pt_i.command == tpcf_pkg::CMD_CANCEL)
      |=> (stage_q == tpcf_pkg::STG_START && state_q == S_WB))
    else $error("cancel did not return to the start stage");

  // the radius is only computed from in-range quotients
  a_sqrt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQS)
      |-> !(ovfx_q || ovfy_q || qx_q[tpcf_pkg::QUO_W-1] || qy_q[tpcf_pkg::QUO_W-1]))
    else $error("square root started on an out-of-range quotient");

endmodule

`default_nettype wire
